[src/npc_pkg.sv]
// Shared types and constants for the nearest palette colour block.
// No dependencies; used by npc_dist and nearest_palette_color_core under src.
`default_nettype none

package npc_pkg;

    localparam int DEF_PALETTE_DEPTH  = 256;
    localparam int DEF_COMPONENT_BITS = 16;
    localparam int FIELD_BITS         = 16;
    localparam int INDEX_BITS         = 8;
    localparam int DIST_BITS          = 34;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic                  operation;
        logic [FIELD_BITS-1:0] red;
        logic [FIELD_BITS-1:0] green;
        logic [FIELD_BITS-1:0] blue;
    } t_in_beat;

    typedef struct packed {
        logic [INDEX_BITS-1:0] nearest_index;
        logic [DIST_BITS-1:0]  nearest_distance_sq;
        logic                  palette_empty;
    } t_out_beat;

    typedef struct packed {
        logic                  vld;
        logic                  busy;
        logic [INDEX_BITS-1:0] idx;
        logic [DIST_BITS-1:0]  dist_sq;
    } t_dist_res;

endpackage

`default_nettype wire

[src/npc_cell.sv]
// One palette cell of the rotating ring: holds a single RGB entry.
// Loaded on append, hands its entry to its neighbour while the ring turns.
`default_nettype none

module npc_cell #(
    parameter int W = 48
) (
    input  wire logic         i_clk,
    input  wire logic         i_load,
    input  wire logic         i_shift,
    input  wire logic [W-1:0] i_load_data,
    input  wire logic [W-1:0] i_next,
    output logic      [W-1:0] o_entry
);

    logic [W-1:0] r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

[src/npc_dist.sv]
// Three-stage squared distance unit: abs difference, square, sum.
// Depends on npc_pkg for the result struct and field widths.
`default_nettype none

module npc_dist
    import npc_pkg::*;
#(
    parameter int CB = DEF_COMPONENT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_vld,
    input  wire logic [INDEX_BITS-1:0] i_idx,
    input  wire logic [3*CB-1:0]       i_entry,
    input  wire logic [3*CB-1:0]       i_colour,
    output t_dist_res                  o_res
);

    localparam int SQ_W  = 2 * CB;
    localparam int SUM_W = 2 * CB + 2;

    logic [2:0]            r_vld;
    logic [INDEX_BITS-1:0] r_idx [3];
    logic [CB-1:0]         n_diff [3];
    logic [CB-1:0]         r_diff [3];
    logic [SQ_W-1:0]       r_sq [3];
    logic [SUM_W-1:0]      r_sum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_entry[k*CB +: CB] > i_colour[k*CB +: CB]) begin
                n_diff[k] = i_entry[k*CB +: CB] - i_colour[k*CB +: CB];
            end else begin
                n_diff[k] = i_colour[k*CB +: CB] - i_entry[k*CB +: CB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx[0] <= i_idx;
        r_idx[1] <= r_idx[0];
        r_idx[2] <= r_idx[1];
        for (int k = 0; k < 3; k++) begin
            r_diff[k] <= n_diff[k];
            r_sq[k]   <= SQ_W'(r_diff[k]) * SQ_W'(r_diff[k]);
        end
        r_sum <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
    end

    always_comb begin
        o_res.vld     = r_vld[2];
        o_res.busy    = |r_vld;
        o_res.idx     = r_idx[2];
        o_res.dist_sq = DIST_BITS'(r_sum);
    end

endmodule

`default_nettype wire

[src/nearest_palette_color_core.sv]
// Nearest palette colour core: ring of palette cells, distance unit, best tracker.
// Append beat: taken with no result. Query beat: the ring always turns once through
// every cell, then drains, and the result beat is registered after the drain.
// One query at a time: the next beat is taken once the result is registered and the
// core is idle again; a held result that blocks the result register delays it.
// Sync active-low reset empties the palette and returns the core to idle.
`default_nettype none

module nearest_palette_color_core
    import npc_pkg::*;
#(
    parameter int PALETTE_DEPTH  = DEF_PALETTE_DEPTH,
    parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_beat i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_beat     o_out_data
);

    localparam int CB    = COMPONENT_BITS;
    localparam int EW    = 3 * CB;
    localparam int CNT_W = $clog2(PALETTE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    logic [1:0]           r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [CNT_W-1:0]     r_step, n_step;
    logic [EW-1:0]        r_colour;
    logic                 r_best_vld, n_best_vld;
    logic [INDEX_BITS-1:0] r_best_idx, n_best_idx;
    logic [DIST_BITS-1:0] r_best_dist, n_best_dist;
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out, n_out;

    logic                 in_acc;
    logic                 do_append;
    logic                 do_query;
    logic                 slot_free;
    logic [EW-1:0]        in_colour;
    logic [EW-1:0]        entry [PALETTE_DEPTH];
    t_dist_res            dres;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign do_append  = in_acc && (i_in_data.operation == OP_APPEND)
                        && (r_count != CNT_W'(PALETTE_DEPTH));
    assign do_query   = in_acc && (i_in_data.operation == OP_QUERY);
    assign slot_free  = !r_out_valid || i_out_ready;
    assign in_colour  = {i_in_data.red[CB-1:0], i_in_data.green[CB-1:0],
                         i_in_data.blue[CB-1:0]};

    for (genvar g = 0; g < PALETTE_DEPTH; g++) begin : g_cell
        npc_cell #(
            .W (EW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_load      (do_append && (r_count == CNT_W'(g))),
            .i_shift     (r_state == ST_RUN),
            .i_load_data (in_colour),
            .i_next      (entry[(g + 1) % PALETTE_DEPTH]),
            .o_entry     (entry[g])
        );
    end

    npc_dist #(
        .CB (CB)
    ) u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    ((r_state == ST_RUN) && (r_step < r_count)),
        .i_idx    (INDEX_BITS'(r_step)),
        .i_entry  (entry[0]),
        .i_colour (r_colour),
        .o_res    (dres)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_best_vld  = r_best_vld;
        n_best_idx  = r_best_idx;
        n_best_dist = r_best_dist;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;

        if (dres.vld && (!r_best_vld || (dres.dist_sq < r_best_dist))) begin
            n_best_vld  = 1'b1;
            n_best_idx  = dres.idx;
            n_best_dist = dres.dist_sq;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (do_append) begin
                    n_count = r_count + 1'b1;
                end
                if (do_query) begin
                    n_state     = ST_RUN;
                    n_step      = '0;
                    n_best_vld  = 1'b0;
                    n_best_idx  = '0;
                    n_best_dist = '0;
                end
            end
            ST_RUN: begin
                n_step = r_step + 1'b1;
                if (r_step == CNT_W'(PALETTE_DEPTH - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!dres.busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (slot_free) begin
                    n_state                   = ST_IDLE;
                    n_out_valid               = 1'b1;
                    n_out.nearest_index       = r_best_idx;
                    n_out.nearest_distance_sq = r_best_dist;
                    n_out.palette_empty       = !r_best_vld;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_best_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_best_vld  <= n_best_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_query) begin
            r_colour <= in_colour;
        end
        r_best_idx  <= n_best_idx;
        r_best_dist <= n_best_dist;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ring turns exactly once per query
    a_step_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step != CNT_W'(PALETTE_DEPTH - 1))
        |=> (r_state == ST_RUN && r_step == $past(r_step) + 1'b1))
        else $error("query step sequence broken");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |=> $stable(r_count))
        else $error("palette count changed during query");

    a_best_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_best_vld == (r_count != '0)))
        else $error("best entry flag disagrees with palette fill");

    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_OUT))
        else $error("result beat raised outside result state");

endmodule

`default_nettype wire

[sim/tb_nearest_palette_color_core.sv]
// Self-checking testbench for nearest_palette_color_core: random append and query beats,
// predicted nearest index and squared distance, randomised stalls on both channels.
// Depends on npc_pkg.sv, npc_cell.sv, npc_dist.sv and nearest_palette_color_core.sv under src.
module tb_nearest_palette_color_core import npc_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAL_DEPTH    = DEF_PALETTE_DEPTH;
    localparam int unsigned RANDOM_ITEMS = 1200;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = PAL_DEPTH + 40;
    localparam int unsigned HOLD_AT      = 150;
    localparam int unsigned HOLD_CYCLES  = 800;
    localparam logic [FIELD_BITS-1:0] COMP_MASK =
        {FIELD_BITS{1'b1}} >> (FIELD_BITS - DEF_COMPONENT_BITS);

    typedef struct {
        t_in_beat beat;
        bit       hold_for_drain;
    } t_pending_beat;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_beat  in_beat   = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_beat;

    t_pending_beat pending_q[$];
    t_out_beat     answer_q[$];
    t_in_beat      shade_pal[$];

    logic [FIELD_BITS-1:0] pal_red   [PAL_DEPTH];
    logic [FIELD_BITS-1:0] pal_green [PAL_DEPTH];
    logic [FIELD_BITS-1:0] pal_blue  [PAL_DEPTH];
    int unsigned pal_fill = 0;

    int unsigned err_count      = 0;
    int unsigned beats_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned kept_appends   = 0;
    int unsigned dropped_appends = 0;
    int unsigned query_count    = 0;
    int unsigned empty_queries  = 0;
    int unsigned stim_counted   = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_stall     = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;
    bit          in_taken       = 1'b0;
    bit          out_taken      = 1'b0;

    nearest_palette_color_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_beat)
    );

    always #6 clk = ~clk;

    function automatic logic [DIST_BITS-1:0] square_gap(input logic [FIELD_BITS-1:0] a,
                                                        input logic [FIELD_BITS-1:0] c);
        logic [DIST_BITS-1:0] w;
        w = (a > c) ? a - c : c - a;
        return w * w;
    endfunction

    function automatic void predict_palette_beat(input t_in_beat b);
        logic [FIELD_BITS-1:0] r, g, bl;
        logic [DIST_BITS-1:0]  d;
        t_out_beat             res;
        r  = b.red & COMP_MASK;
        g  = b.green & COMP_MASK;
        bl = b.blue & COMP_MASK;
        if (b.operation == OP_APPEND) begin
            if (pal_fill < PAL_DEPTH) begin
                pal_red[pal_fill]   = r;
                pal_green[pal_fill] = g;
                pal_blue[pal_fill]  = bl;
                pal_fill++;
                kept_appends++;
            end else begin
                dropped_appends++;
            end
            return;
        end
        query_count++;
        res = '0;
        if (pal_fill == 0) begin
            res.palette_empty = 1'b1;
            empty_queries++;
        end else begin
            res.nearest_distance_sq = square_gap(pal_red[0], r) + square_gap(pal_green[0], g)
                                    + square_gap(pal_blue[0], bl);
            for (int unsigned k = 1; k < pal_fill; k++) begin
                d = square_gap(pal_red[k], r) + square_gap(pal_green[k], g)
                  + square_gap(pal_blue[k], bl);
                if (d < res.nearest_distance_sq) begin
                    res.nearest_distance_sq = d;
                    res.nearest_index       = k[INDEX_BITS-1:0];
                end
            end
        end
        answer_q = {answer_q, res};
    endfunction

    function automatic void check_result(input t_out_beat got);
        t_out_beat want;
        if (answer_q.size() == 0) begin
            $error("result beat with no query outstanding: index %0d dist %0d empty %0b",
                   got.nearest_index, got.nearest_distance_sq, got.palette_empty);
            err_count++;
            return;
        end
        want = answer_q.pop_front();
        if (got.nearest_index !== want.nearest_index) begin
            $error("nearest_index: expected %0d, got %0d", want.nearest_index, got.nearest_index);
            err_count++;
        end
        if (got.nearest_distance_sq !== want.nearest_distance_sq) begin
            $error("nearest_distance_sq: expected %0d, got %0d",
                   want.nearest_distance_sq, got.nearest_distance_sq);
            err_count++;
        end
        if (got.palette_empty !== want.palette_empty) begin
            $error("palette_empty: expected %0b, got %0b", want.palette_empty, got.palette_empty);
            err_count++;
        end
    endfunction

    // every third stretch of 40 beats runs without idling
    function automatic int unsigned draw_wait(input int unsigned seq);
        if ((seq / 40) % 3 == 2) return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic logic [FIELD_BITS-1:0] draw_level();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return {3'($urandom_range(0, 7)), 13'd0};
            default: return FIELD_BITS'($urandom);
        endcase
    endfunction

    function automatic t_in_beat near_entry();
        t_in_beat e;
        e = shade_pal[$urandom_range(0, shade_pal.size() - 1)];
        if ($urandom_range(0, 2) != 0) begin
            e.red   = e.red ^ FIELD_BITS'($urandom_range(0, 15));
            e.green = e.green ^ FIELD_BITS'($urandom_range(0, 15));
            e.blue  = e.blue ^ FIELD_BITS'($urandom_range(0, 15));
        end
        return e;
    endfunction

    function automatic void queue_beat(input logic op, input logic [FIELD_BITS-1:0] r,
                                       input logic [FIELD_BITS-1:0] g,
                                       input logic [FIELD_BITS-1:0] b, input bit drain);
        t_pending_beat p;
        p.beat.operation = op;
        p.beat.red       = r;
        p.beat.green     = g;
        p.beat.blue      = b;
        p.hold_for_drain = drain;
        pending_q = {pending_q, p};
        if (op == OP_QUERY || shade_pal.size() < PAL_DEPTH) stim_counted++;
        if (op == OP_APPEND && shade_pal.size() < PAL_DEPTH) shade_pal = {shade_pal, p.beat};
    endfunction

    // sampling at the rising edge
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            check_result(out_beat);
            results_seen++;
            out_taken = 1'b1;
        end
        if (rst_n && in_valid && in_ready) begin
            predict_palette_beat(in_beat);
            beats_sent++;
            in_taken = 1'b1;
        end
    end

    // sender
    always @(negedge clk) begin
        bit fired;
        fired    = in_taken;
        in_taken = 1'b0;
        if (fired) send_gap = draw_wait(beats_sent);
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || fired) begin
            if (send_gap != 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (pending_q.size() != 0 &&
                         !(pending_q[0].hold_for_drain && answer_q.size() != 0)) begin
                in_beat  <= pending_q[0].beat;
                in_valid <= 1'b1;
                void'(pending_q.pop_front());
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(negedge clk) begin
        if (out_taken) begin
            out_taken  = 1'b0;
            recv_stall = draw_wait(results_seen);
        end
        if (!rst_n || hold_left != 0) begin
            out_ready <= 1'b0;
        end else if (recv_stall != 0) begin
            recv_stall--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // one long receiver hold-off so the core backs up onto its input
    always @(negedge clk) begin
        if (!hold_done && results_seen == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    initial begin
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, answer_q.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        bit       full;
        bit       drain;
        t_in_beat c;

        // empty palette, extremes, duplicate and equidistant entries
        queue_beat(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_QUERY,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_beat(OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_QUERY,  16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_beat(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_APPEND, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_beat(OP_APPEND, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_QUERY,  16'h8000, 16'h8000, 16'h8000, 1'b0);
        queue_beat(OP_QUERY,  16'h7FFF, 16'h8000, 16'h7FFF, 1'b0);
        queue_beat(OP_APPEND, 16'h1000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_APPEND, 16'h3000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_QUERY,  16'h2000, 16'h0000, 16'h0000, 1'b0);
        queue_beat(OP_APPEND, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
        queue_beat(OP_APPEND, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        queue_beat(OP_QUERY,  16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
        queue_beat(OP_QUERY,  16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        queue_beat(OP_QUERY,  16'h0000, 16'hFFFF, 16'h0000, 1'b0);

        stim_counted = 0;
        while (stim_counted < RANDOM_ITEMS) begin
            full  = shade_pal.size() >= PAL_DEPTH;
            drain = (stim_counted % 300 == 0);
            if (full ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 1) == 0)) begin
                if (shade_pal.size() != 0 && $urandom_range(0, 7) == 0) begin
                    c = shade_pal[$urandom_range(0, shade_pal.size() - 1)];
                end else begin
                    c.red   = draw_level();
                    c.green = draw_level();
                    c.blue  = draw_level();
                end
                queue_beat(OP_APPEND, c.red, c.green, c.blue, drain);
            end else begin
                if (shade_pal.size() != 0 && $urandom_range(0, 1) == 0) begin
                    c = near_entry();
                end else begin
                    c.red   = draw_level();
                    c.green = draw_level();
                    c.blue  = draw_level();
                end
                queue_beat(OP_QUERY, c.red, c.green, c.blue, drain);
            end
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        while (pending_q.size() != 0 || in_valid || answer_q.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d queries (%0d on an empty palette), %0d result beats checked",
                 query_count, empty_queries, results_seen);
        $display("palette loaded with %0d entries, %0d appends dropped while full",
                 kept_appends, dropped_appends);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
